// ----- rtl/charlieplex_breathing_led_pwm_macros.svh -----
// Assertion macros used by the checker file of the charlieplex LED driver.
`ifndef CHARLIEPLEX_BREATHING_LED_PWM_MACROS_SVH
`define CHARLIEPLEX_BREATHING_LED_PWM_MACROS_SVH

// Same-cycle implication, sampled on clk, switched off during reset.
`define CBLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, switched off during reset.
`define CBLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cblp_pkg.sv -----
// Constants, tables and state types for the charlieplexed breathing LED driver.
`default_nettype none

package cblp_pkg;

  localparam int unsigned LED_SLOTS     = 6;
  localparam int unsigned SLOT_W        = 3;
  localparam int unsigned PIN_W         = 3;
  localparam int unsigned DUTY_W        = 8;
  localparam int unsigned INTERVAL_W    = 16;
  localparam int unsigned PHASE_W       = 4;

  localparam logic [SLOT_W-1:0]     LAST_SLOT      = 3'd5;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd2048;
  localparam logic [PHASE_W-1:0]    PHASE_RESET    = 4'd4;
  localparam logic [PHASE_W-1:0]    PHASE_TOP      = 4'd4;
  localparam logic [PHASE_W-1:0]    PHASE_BOTTOM   = 4'hD;   // -3
  localparam logic [PHASE_W-1:0]    PHASE_MIN_NEG  = 4'h8;   // -8
  localparam logic [DUTY_W-1:0]     DUTY_FULL      = 8'd255;
  localparam logic [DUTY_W-1:0]     DUTY_OFF       = 8'd0;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [PIN_W-1:0]  pins_t;
  typedef logic [DUTY_W-1:0] duty_t;

  typedef struct packed {
    pins_t level;
    pins_t direction;
    slot_t slot_index;
  } drive_word_t;

  // Output enable pattern of each slot.
  function automatic pins_t dir_of(input slot_t s);
    pins_t d;
    case (s)
      3'd0, 3'd1: d = 3'b011;
      3'd2, 3'd3: d = 3'b101;
      3'd4, 3'd5: d = 3'b110;
      default:    d = 3'b000;
    endcase
    return d;
  endfunction

  // Drive level of each slot when lit.
  function automatic pins_t lvl_of(input slot_t s);
    pins_t l;
    case (s)
      3'd0, 3'd3: l = 3'b001;
      3'd1, 3'd4: l = 3'b010;
      3'd2, 3'd5: l = 3'b100;
      default:    l = 3'b000;
    endcase
    return l;
  endfunction

  // Sine brightness by phase magnitude, saturating past the last entry.
  function automatic duty_t sine_of(input logic [PHASE_W-1:0] mag);
    duty_t v;
    case (mag)
      4'd0:    v = 8'd0;
      4'd1:    v = 8'd49;
      4'd2:    v = 8'd141;
      4'd3:    v = 8'd212;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/charlieplex_breathing_led_pwm.sv -----
// Top level of the charlieplexed breathing LED PWM driver.
//
//  channel   | direction | payload
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | tdata[0] tick
//  m_axis    | out       | tdata slot_index, pin_direction, pin_level; tlast
//  cfg       | in        | cfg_wr_data interval_ticks, written on cfg_wr_en
//
// A tick request yields six drive words, one per cycle while the output is
// not stalled; the slot counter feeding the output register steps through them.
// The next tick is taken on the same edge that loads slot five, so runs
// follow with no gap. A zero tick is taken and yields nothing.
// Reset (rst, synchronous) clears the sequencer, output valid and LED state.
// Output stalls hold the output register and the slot counter.
`default_nettype none

module charlieplex_breathing_led_pwm (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [2:0] slot_index, [5:3] pin_direction,
                                           // [8:6] pin_level, [15:9] zero
  output logic             m_axis_tlast,   // last_slot
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data     // interval_ticks
);

  logic [cblp_pkg::INTERVAL_W-1:0] interval_ticks;
  logic [cblp_pkg::DUTY_W-1:0]     pwm_phase;
  logic [cblp_pkg::INTERVAL_W-1:0] interval_count;
  logic [cblp_pkg::PHASE_W-1:0]    breathe_phase;
  logic                            alternate_mode;

  logic                active;
  cblp_pkg::slot_t     slot;
  logic                out_valid;
  cblp_pkg::drive_word_t out_word;
  logic                out_last;

  logic                load;
  logic                run_end;
  logic                in_accept;
  logic [cblp_pkg::PHASE_W-1:0]    mag;
  cblp_pkg::duty_t     duty;
  logic                lit;
  cblp_pkg::drive_word_t word_next;
  logic [cblp_pkg::INTERVAL_W:0]   cnt_inc;
  logic                update;

  assign load      = active && (!out_valid || m_axis_tready);
  assign run_end   = load && (slot == cblp_pkg::LAST_SLOT);
  assign s_axis_tready = !active || run_end;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Magnitude of the signed breathing phase; -8 saturates like any large one.
  always_comb begin
    if (breathe_phase == cblp_pkg::PHASE_MIN_NEG) begin
      mag = cblp_pkg::PHASE_MIN_NEG;
    end else if (breathe_phase[cblp_pkg::PHASE_W-1]) begin
      mag = -breathe_phase;
    end else begin
      mag = breathe_phase;
    end
  end

  always_comb begin
    case (slot)
      3'd0, 3'd1: duty = cblp_pkg::sine_of(mag);
      3'd2:       duty = alternate_mode ? cblp_pkg::DUTY_OFF : cblp_pkg::DUTY_FULL;
      3'd3:       duty = alternate_mode ? cblp_pkg::DUTY_FULL : cblp_pkg::DUTY_OFF;
      default:    duty = cblp_pkg::DUTY_FULL;
    endcase
  end

  assign lit = pwm_phase < duty;

  always_comb begin
    word_next.slot_index = slot;
    word_next.direction  = cblp_pkg::dir_of(slot);
    word_next.level      = lit ? cblp_pkg::lvl_of(slot) : 3'b000;
  end

  assign cnt_inc = {1'b0, interval_count} + 17'd1;
  assign update  = cnt_inc >= {1'b0, interval_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ticks <= cblp_pkg::INTERVAL_RESET;
    end else if (cfg_wr_en) begin
      interval_ticks <= cfg_wr_data;
    end
  end

  // Slot sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      slot   <= '0;
    end else if (in_accept) begin
      active <= s_axis_tdata[0];
      slot   <= '0;
    end else if (run_end) begin
      active <= 1'b0;
    end else if (load) begin
      slot <= slot + 3'd1;
    end
  end

  // LED state advances once a run's last word is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_phase      <= '0;
      interval_count <= '0;
      breathe_phase  <= cblp_pkg::PHASE_RESET;
      alternate_mode <= 1'b0;
    end else if (run_end) begin
      pwm_phase <= pwm_phase + 8'd1;
      if (update) begin
        interval_count <= '0;
        breathe_phase  <= (breathe_phase == cblp_pkg::PHASE_TOP) ?
                          cblp_pkg::PHASE_BOTTOM : breathe_phase + 4'd1;
        alternate_mode <= !alternate_mode;
      end else begin
        interval_count <= cnt_inc[cblp_pkg::INTERVAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= word_next;
      out_last <= (slot == cblp_pkg::LAST_SLOT);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_word};
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

// ----- rtl/cblp_checker.sv -----
// Port-level checker for the charlieplex LED driver, bound to the top level.
`default_nettype none

`include "charlieplex_breathing_led_pwm_macros.svh"

module cblp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // A stalled result request stays offered.
  `CBLP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // Words of a run come without gaps once one is taken.
  `CBLP_ASSERT_NEXT(a_run_gapless, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside a run")

  // tlast marks the sixth slot and only it.
  `CBLP_ASSERT_NOW(a_last_slot, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[2:0] == cblp_pkg::LAST_SLOT), "tlast not on slot five")

  // A pin is driven high only where it is enabled.
  `CBLP_ASSERT_NOW(a_level_in_dir, m_axis_tvalid, (m_axis_tdata[8:6] & ~m_axis_tdata[5:3]) == 3'b000, "level on a disabled pin")

endmodule

bind charlieplex_breathing_led_pwm cblp_checker u_cblp_checker (.*);

`default_nettype wire
